// File: rtl/core/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

   localparam int CMD_WIDTH = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   // Control that rides along the divider chain with each beat.
   typedef struct packed {
      logic valid;
      logic is_div;
      logic dz;
      logic big_re;
      logic big_im;
      logic neg_re;
      logic neg_im;
   } ctl_type;

endpackage
`default_nettype wire

// File: rtl/core/cau_front.sv
// Front end: operand products and sums, two register stages.
`default_nettype none
module cau_front #(
   parameter int DATA_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire cau_pkg::cmd_type              in_cmd,
   input  wire logic signed [DATA_WIDTH-1:0]  a_re,
   input  wire logic signed [DATA_WIDTH-1:0]  a_im,
   input  wire logic signed [DATA_WIDTH-1:0]  b_re,
   input  wire logic signed [DATA_WIDTH-1:0]  b_im,
   output logic                               out_valid,
   output cau_pkg::cmd_type                   out_cmd,
   output logic signed [2*DATA_WIDTH:0]       num_re,
   output logic signed [2*DATA_WIDTH:0]       num_im,
   output logic        [2*DATA_WIDTH-1:0]     den
);
   localparam int PW = 2 * DATA_WIDTH;
   localparam int MW = PW + 1;
   localparam int SW = DATA_WIDTH + 1;

   logic                 valid_a_ff, valid_b_ff;
   cau_pkg::cmd_type     cmd_a_ff, cmd_b_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, sq_r_ff, sq_i_ff;
   logic signed [SW-1:0] s_re_ff, s_im_ff;
   logic signed [SW-1:0] s_re_in, s_im_in;
   logic signed [MW-1:0] num_re_ff, num_im_ff, num_re_in, num_im_in;
   logic        [PW-1:0] den_ff, den_in;

   function automatic logic cmd_type_is_add(input cau_pkg::cmd_type c);
      return c == cau_pkg::CMD_ADD;
   endfunction

   always_comb begin
      if (cmd_type_is_add(in_cmd)) begin
         s_re_in = SW'(a_re) + SW'(b_re);
         s_im_in = SW'(a_im) + SW'(b_im);
      end else begin
         s_re_in = SW'(a_re) - SW'(b_re);
         s_im_in = SW'(a_im) - SW'(b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
      cmd_a_ff <= in_cmd;
      p_rr_ff  <= a_re * b_re;
      p_ii_ff  <= a_im * b_im;
      p_ri_ff  <= a_re * b_im;
      p_ir_ff  <= a_im * b_re;
      sq_r_ff  <= b_re * b_re;
      sq_i_ff  <= b_im * b_im;
      s_re_ff  <= s_re_in;
      s_im_ff  <= s_im_in;
   end

   always_comb begin
      case (cmd_a_ff)
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
            num_re_in = MW'(s_re_ff);
            num_im_in = MW'(s_im_ff);
         end
         cau_pkg::CMD_MUL: begin
            num_re_in = MW'(p_rr_ff) - MW'(p_ii_ff);
            num_im_in = MW'(p_ri_ff) + MW'(p_ir_ff);
         end
         default: begin
            num_re_in = MW'(p_rr_ff) + MW'(p_ii_ff);
            num_im_in = MW'(p_ir_ff) - MW'(p_ri_ff);
         end
      endcase
      // squares are nonnegative and their sum fits PW bits unsigned
      den_in = $unsigned(sq_r_ff) + $unsigned(sq_i_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else begin
         valid_b_ff <= valid_a_ff;
      end
      cmd_b_ff  <= cmd_a_ff;
      num_re_ff <= num_re_in;
      num_im_ff <= num_im_in;
      den_ff    <= den_in;
   end

   assign out_valid = valid_b_ff;
   assign out_cmd   = cmd_b_ff;
   assign num_re    = num_re_ff;
   assign num_im    = num_im_ff;
   assign den       = den_ff;

endmodule
`default_nettype wire

// File: rtl/core/cau_div_cell.sv
// One restoring divider cell: resolves one quotient bit for both parts.
`default_nettype none
module cau_div_cell #(
   parameter int RW    = 41,
   parameter int DW    = 32,
   parameter int QB    = 17,
   parameter int EW    = 60,
   parameter int SHIFT = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cau_pkg::ctl_type  ctl_in,
   input  wire logic [RW-1:0]     rem_re_in,
   input  wire logic [RW-1:0]     rem_im_in,
   input  wire logic [DW-1:0]     den_in,
   input  wire logic [QB-1:0]     q_re_in,
   input  wire logic [QB-1:0]     q_im_in,
   output cau_pkg::ctl_type       ctl_out,
   output logic [RW-1:0]          rem_re_out,
   output logic [RW-1:0]          rem_im_out,
   output logic [DW-1:0]          den_out,
   output logic [QB-1:0]          q_re_out,
   output logic [QB-1:0]          q_im_out
);
   cau_pkg::ctl_type ctl_ff;
   logic [RW-1:0]    rem_re_ff, rem_im_ff, rem_re_in2, rem_im_in2;
   logic [DW-1:0]    den_ff;
   logic [QB-1:0]    q_re_ff, q_im_ff, q_re_in2, q_im_in2;
   logic [EW-1:0]    dsh, er, ei;
   logic             bit_re, bit_im;

   always_comb begin
      dsh    = EW'(den_in) << SHIFT;
      er     = EW'(rem_re_in);
      ei     = EW'(rem_im_in);
      bit_re = er >= dsh;
      bit_im = ei >= dsh;
      if (ctl_in.is_div) begin
         rem_re_in2 = bit_re ? RW'(er - dsh) : rem_re_in;
         rem_im_in2 = bit_im ? RW'(ei - dsh) : rem_im_in;
         q_re_in2   = {q_re_in[QB-2:0], bit_re};
         q_im_in2   = {q_im_in[QB-2:0], bit_im};
      end else begin
         // non-divide beats carry their clamped magnitude straight through
         rem_re_in2 = rem_re_in;
         rem_im_in2 = rem_im_in;
         q_re_in2   = q_re_in;
         q_im_in2   = q_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      rem_re_ff <= rem_re_in2;
      rem_im_ff <= rem_im_in2;
      den_ff    <= den_in;
      q_re_ff   <= q_re_in2;
      q_im_ff   <= q_im_in2;
   end

   assign ctl_out    = ctl_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign den_out    = den_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;

endmodule
`default_nettype wire

// File: rtl/core/complex_arithmetic_unit.sv
// Top level: complex add/sub/mul/div on signed fixed point, fully pipelined.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------
//  request | req_command, req_a_re/im, req_b_re/im   | start high, busy low
//  result  | rsp_res_re/im, rsp_overflow, rsp_div_zero | rsp_valid, one cycle
//
// A new beat is taken every cycle; busy stays low. Each result passes
// through two front stages (products, sums), one setup stage, one divider
// cell per quotient bit (DATA_WIDTH+1 cells), and the output register.
// Results leave in request order. Reset clears only the valid bits and the
// divider control words along the pipe. The receiver cannot stall.
`default_nettype none
module complex_arithmetic_unit #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [cau_pkg::CMD_WIDTH-1:0]      req_command,
   input  wire logic signed [DATA_WIDTH-1:0]       req_a_re,
   input  wire logic signed [DATA_WIDTH-1:0]       req_a_im,
   input  wire logic signed [DATA_WIDTH-1:0]       req_b_re,
   input  wire logic signed [DATA_WIDTH-1:0]       req_b_im,
   output logic                                    rsp_valid,
   output logic signed [DATA_WIDTH-1:0]            rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]            rsp_res_im,
   output logic                                    rsp_overflow,
   output logic                                    rsp_div_zero
);
   localparam int W  = DATA_WIDTH;
   localparam int DW = 2 * W;
   localparam int MW = DW + 1;
   localparam int RW = MW + FRAC_BITS;
   localparam int QB = W + 1;
   localparam int EW = RW + QB + 1;
   localparam logic [QB-1:0] HALF = QB'(1) << (W - 1);
   localparam logic [QB-1:0] OVER = HALF + QB'(1);

   logic                  fr_valid;
   cau_pkg::cmd_type      fr_cmd;
   logic signed [MW-1:0]  fr_num_re, fr_num_im;
   logic [DW-1:0]         fr_den;

   cau_front #(.DATA_WIDTH(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start & ~busy),
      .in_cmd    (cau_pkg::cmd_type'(req_command)),
      .a_re      (req_a_re),
      .a_im      (req_a_im),
      .b_re      (req_b_re),
      .b_im      (req_b_im),
      .out_valid (fr_valid),
      .out_cmd   (fr_cmd),
      .num_re    (fr_num_re),
      .num_im    (fr_num_im),
      .den       (fr_den)
   );

   assign busy = 1'b0;

   // setup stage: sign/magnitude, clamp add/sub/mul, divider zero/overflow check
   function automatic logic [QB-1:0] clamp_q(input logic [MW-1:0] m);
      return (m > MW'(HALF)) ? OVER : QB'(m);
   endfunction

   cau_pkg::ctl_type ctl_in;
   logic [MW-1:0]    mag_re, mag_im;
   logic [RW-1:0]    rem_re_in, rem_im_in;
   logic [QB-1:0]    q_re_in, q_im_in;
   logic [EW-1:0]    lim;

   always_comb begin
      mag_re = fr_num_re[MW-1] ? $unsigned(-fr_num_re) : $unsigned(fr_num_re);
      mag_im = fr_num_im[MW-1] ? $unsigned(-fr_num_im) : $unsigned(fr_num_im);
      rem_re_in = RW'(mag_re) << FRAC_BITS;
      rem_im_in = RW'(mag_im) << FRAC_BITS;
      lim = EW'(fr_den) << QB;
      ctl_in = '0;
      ctl_in.valid  = fr_valid;
      ctl_in.neg_re = fr_num_re[MW-1];
      ctl_in.neg_im = fr_num_im[MW-1];
      q_re_in = '0;
      q_im_in = '0;
      case (fr_cmd)
         cau_pkg::CMD_ADD, cau_pkg::CMD_SUB: begin
            q_re_in = clamp_q(mag_re);
            q_im_in = clamp_q(mag_im);
         end
         cau_pkg::CMD_MUL: begin
            q_re_in = clamp_q(mag_re >> FRAC_BITS);
            q_im_in = clamp_q(mag_im >> FRAC_BITS);
         end
         default: begin
            if (fr_den == '0) begin
               ctl_in.dz     = 1'b1;
               ctl_in.neg_re = 1'b0;
               ctl_in.neg_im = 1'b0;
            end else begin
               ctl_in.is_div = 1'b1;
               ctl_in.big_re = EW'(rem_re_in) >= lim;
               ctl_in.big_im = EW'(rem_im_in) >= lim;
            end
         end
      endcase
   end

   cau_pkg::ctl_type ch_ctl [QB+1];
   logic [RW-1:0]    ch_rem_re [QB+1];
   logic [RW-1:0]    ch_rem_im [QB+1];
   logic [DW-1:0]    ch_den [QB+1];
   logic [QB-1:0]    ch_q_re [QB+1];
   logic [QB-1:0]    ch_q_im [QB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ctl[0] <= '0;
      end else begin
         ch_ctl[0] <= ctl_in;
      end
      ch_rem_re[0] <= rem_re_in;
      ch_rem_im[0] <= rem_im_in;
      ch_den[0]    <= fr_den;
      ch_q_re[0]   <= q_re_in;
      ch_q_im[0]   <= q_im_in;
   end

   for (genvar i = 0; i < QB; i++) begin : g_cell
      cau_div_cell #(
         .RW(RW), .DW(DW), .QB(QB), .EW(EW), .SHIFT(QB - 1 - i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl_in     (ch_ctl[i]),
         .rem_re_in  (ch_rem_re[i]),
         .rem_im_in  (ch_rem_im[i]),
         .den_in     (ch_den[i]),
         .q_re_in    (ch_q_re[i]),
         .q_im_in    (ch_q_im[i]),
         .ctl_out    (ch_ctl[i+1]),
         .rem_re_out (ch_rem_re[i+1]),
         .rem_im_out (ch_rem_im[i+1]),
         .den_out    (ch_den[i+1]),
         .q_re_out   (ch_q_re[i+1]),
         .q_im_out   (ch_q_im[i+1])
      );
   end

   // saturate a sign/magnitude part; returns {clipped, value}
   function automatic logic [W:0] sat(input logic neg, input logic [QB-1:0] q);
      logic [QB-1:0] m;
      logic          ov;
      logic [W-1:0]  v;
      m  = q;
      ov = 1'b0;
      if (neg) begin
         if (m > HALF) begin
            ov = 1'b1;
            m  = HALF;
         end
         v = W'(-m);
      end else begin
         if (m > HALF - QB'(1)) begin
            ov = 1'b1;
            m  = HALF - QB'(1);
         end
         v = W'(m);
      end
      return {ov, v};
   endfunction

   cau_pkg::ctl_type last;
   logic [W:0]       sr, si;
   logic             valid_ff, ov_ff, dz_ff;
   logic [W-1:0]     re_ff, im_ff;

   always_comb begin
      last = ch_ctl[QB];
      sr = sat(last.neg_re, last.big_re ? OVER : ch_q_re[QB]);
      si = sat(last.neg_im, last.big_im ? OVER : ch_q_im[QB]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= last.valid;
      end
      re_ff <= sr[W-1:0];
      im_ff <= si[W-1:0];
      ov_ff <= sr[W] | si[W];
      dz_ff <= last.dz;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_res_re   = $signed(re_ff);
   assign rsp_res_im   = $signed(im_ff);
   assign rsp_overflow = ov_ff;
   assign rsp_div_zero = dz_ff;

endmodule
`default_nettype wire
